>>> rtl/core/ohf_pkg.sv
// Shared types, widths and helpers for the outflow boundary halo fill block.
package ohf_pkg;

    // Value format: signed fixed point, VALUE_WIDTH bits with FRAC_BITS fraction bits
    localparam int VALUE_WIDTH    = 48;
    localparam int FRAC_BITS      = 16;

    // Internal widths of the reflection datapath
    localparam int PROD_WIDTH     = 2 * VALUE_WIDTH;       // w*w product
    localparam int SUM_WIDTH      = 2 * VALUE_WIDTH + 1;   // sum of three products
    localparam int DBL_WIDTH      = 2 * VALUE_WIDTH + 2;   // doubled dot product
    localparam int PROD2_WIDTH    = DBL_WIDTH + VALUE_WIDTH;
    localparam int NUM_WIDTH      = PROD2_WIDTH + 1;       // reflection numerator
    localparam int QUO_BITS       = VALUE_WIDTH + 1;       // quotient magnitude bits
    localparam int SAT_WIDTH      = VALUE_WIDTH + 4;       // pre-saturation width

    // Multiplier slices the second operand into chunks, one chunk per stage
    localparam int MUL_CHUNK      = 8;
    localparam int MUL_LAT        = (VALUE_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK + 2;
    localparam int DIV_LAT        = QUO_BITS + 3;

    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 32;

    typedef logic signed [VALUE_WIDTH-1:0] val_t;

    typedef enum logic [1:0] {
        FUNC_VELOCITY    = 2'd0,
        FUNC_PRESSURE    = 2'd1,
        FUNC_TEMPERATURE = 2'd2,
        FUNC_SPECIES     = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_EXIT_MODE  = 2'd0,
        CFG_NORMAL_OUT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        func_t func;
        val_t  first_a;
        val_t  first_b;
        val_t  first_c;
        val_t  second_a;
        val_t  second_b;
        val_t  second_c;
        val_t  face_x;
        val_t  face_y;
        val_t  face_z;
    } in_item_t;

    typedef struct packed {
        val_t halo_a;
        val_t halo_b;
        val_t halo_c;
        logic reverse_flow;
    } out_item_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic           is_vel;
        logic           npo;
        val_t [2:0]     u1;
        val_t [2:0]     s;
        val_t [2:0]     alt;   // extrapolated velocity, or scalar result in [0]
    } entry_t;

    // Entry plus decisions made once the dot products are known
    typedef struct packed {
        entry_t ent;
        logic   nn_zero;
        logic   leave;
    } side_t;

    // Clamp a wide signed value into the value range
    function automatic val_t sat_val(input logic signed [SAT_WIDTH-1:0] v);
        val_t result;
        if (&v[SAT_WIDTH-1:VALUE_WIDTH-1] || ~|v[SAT_WIDTH-1:VALUE_WIDTH-1]) begin
            result = v[VALUE_WIDTH-1:0];
        end else if (v[SAT_WIDTH-1]) begin
            result = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end else begin
            result = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
        return result;
    endfunction

endpackage

>>> rtl/core/ohf_mul.sv
// Pipelined signed multiplier, one chunk of the second operand per stage.
module ohf_mul import ohf_pkg::*; #(
    parameter int A_WIDTH = VALUE_WIDTH,
    parameter int B_WIDTH = VALUE_WIDTH
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [A_WIDTH-1:0]         a,
    input  logic signed [B_WIDTH-1:0]         b,
    output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

    localparam int NCH    = (B_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BP     = NCH * MUL_CHUNK;
    localparam int PW     = A_WIDTH + B_WIDTH;
    localparam int ACC_W  = A_WIDTH + BP;

    logic [A_WIDTH-1:0] a_mag;
    logic [B_WIDTH-1:0] b_mag;
    logic [A_WIDTH-1:0] am_reg  [0:NCH-1];
    logic [BP-1:0]      bm_reg  [0:NCH-1];
    logic               ng_reg  [0:NCH];
    logic [ACC_W-1:0]   acc_reg [0:NCH];
    logic [ACC_W-1:0]   part    [1:NCH];
    logic [PW-1:0]      acc_t;
    logic [PW-1:0]      p_reg;

    assign a_mag = a[A_WIDTH-1] ? -a : a;
    assign b_mag = b[B_WIDTH-1] ? -b : b;

    // partial product of each stage
    for (genvar k = 1; k <= NCH; k++) begin : g_part
        assign part[k] = (ACC_W'(am_reg[k-1])
                          * ACC_W'(bm_reg[k-1][(k-1)*MUL_CHUNK +: MUL_CHUNK]))
                         << ((k-1) * MUL_CHUNK);
    end

    assign acc_t = acc_reg[NCH][PW-1:0];

    // advance magnitudes, signs and running sums
    always_ff @(posedge aclk) begin
        if (en) begin
            am_reg[0]  <= a_mag;
            bm_reg[0]  <= BP'(b_mag);
            ng_reg[0]  <= a[A_WIDTH-1] ^ b[B_WIDTH-1];
            acc_reg[0] <= '0;
            for (int k = 1; k < NCH; k++) begin
                am_reg[k] <= am_reg[k-1];
                bm_reg[k] <= bm_reg[k-1];
            end
            for (int k = 1; k <= NCH; k++) begin
                ng_reg[k]  <= ng_reg[k-1];
                acc_reg[k] <= acc_reg[k-1] + part[k];
            end
            p_reg <= ng_reg[NCH] ? -acc_t : acc_t;
        end
    end

    assign p = signed'(p_reg);

endmodule

>>> rtl/core/ohf_div.sv
// Pipelined restoring divider for the reflection, with rounding and saturation.
module ohf_div import ohf_pkg::*; (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [NUM_WIDTH-1:0] num,
    input  logic [SUM_WIDTH-1:0]        den,
    output val_t                        q
);

    logic [NUM_WIDTH-1:0] mag_reg [0:QUO_BITS];
    logic [QUO_BITS-1:0]  quo_reg [0:QUO_BITS];
    logic [SUM_WIDTH-1:0] den_reg [0:QUO_BITS];
    logic                 neg_reg [0:QUO_BITS];
    logic [NUM_WIDTH-1:0] mag_nx  [1:QUO_BITS];
    logic [QUO_BITS-1:0]  quo_nx  [1:QUO_BITS];
    logic [QUO_BITS:0]    qr_reg;
    logic                 negr_reg;
    logic                 inc;
    logic signed [SAT_WIDTH-1:0] qs;
    val_t                 q_reg;

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= QUO_BITS; k++) begin : g_step
        logic [NUM_WIDTH-1:0] sd;
        logic                 ge;
        assign sd        = NUM_WIDTH'(den_reg[k-1]) << (QUO_BITS - k);
        assign ge        = mag_reg[k-1] >= sd;
        assign mag_nx[k] = ge ? mag_reg[k-1] - sd : mag_reg[k-1];
        assign quo_nx[k] = quo_reg[k-1] | (ge ? (QUO_BITS'(1) << (QUO_BITS - k)) : '0);
    end

    // round half away from zero on the magnitude
    assign inc = {mag_reg[QUO_BITS], 1'b0} >= (NUM_WIDTH+1)'(den_reg[QUO_BITS]);
    assign qs  = negr_reg ? -signed'(SAT_WIDTH'(qr_reg)) : signed'(SAT_WIDTH'(qr_reg));

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg[0] <= num[NUM_WIDTH-1] ? -num : num;
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num[NUM_WIDTH-1];
            for (int k = 1; k <= QUO_BITS; k++) begin
                mag_reg[k] <= mag_nx[k];
                quo_reg[k] <= quo_nx[k];
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            qr_reg   <= (QUO_BITS+1)'(quo_reg[QUO_BITS]) + (QUO_BITS+1)'(inc);
            negr_reg <= neg_reg[QUO_BITS];
            q_reg    <= sat_val(qs);
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/core/ohf_front.sv
// Front end: configuration registers, item intake and classification.
module ohf_front import ohf_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic                      q_full,
    output logic                      push,
    output entry_t                    push_entry
);

    logic exit_mode_reg;
    logic npo_reg;
    logic signed [SAT_WIDTH-1:0] u1x [3];
    logic signed [SAT_WIDTH-1:0] u2x [3];
    logic signed [SAT_WIDTH-1:0] ext [3];
    logic signed [SAT_WIDTH-1:0] one;
    logic signed [SAT_WIDTH-1:0] pos;
    logic signed [SAT_WIDTH-1:0] lim;
    logic signed [SAT_WIDTH-1:0] res;
    logic is_vel;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign push      = s_valid && !q_full;

    // write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exit_mode_reg <= 1'b0;
            npo_reg       <= 1'b1;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_EXIT_MODE) begin
                exit_mode_reg <= cfg_data[0];
            end else if (cfg_index == CFG_NORMAL_OUT) begin
                npo_reg <= cfg_data[0];
            end
        end
    end

    // extrapolate every component: 2*first - second
    always_comb begin
        u1x[0] = SAT_WIDTH'(s_item.first_a);
        u1x[1] = SAT_WIDTH'(s_item.first_b);
        u1x[2] = SAT_WIDTH'(s_item.first_c);
        u2x[0] = SAT_WIDTH'(s_item.second_a);
        u2x[1] = SAT_WIDTH'(s_item.second_b);
        u2x[2] = SAT_WIDTH'(s_item.second_c);
        for (int i = 0; i < 3; i++) begin
            ext[i] = (u1x[i] <<< 1) - u2x[i];
        end
    end

    // scalar rules
    always_comb begin
        one = SAT_WIDTH'(1) <<< FRAC_BITS;
        pos = (ext[0] > 0) ? ext[0] : '0;
        lim = (ext[0] < one) ? ext[0] : one;
        res = u1x[0];
        if (!exit_mode_reg) begin
            res = (s_item.func == FUNC_PRESSURE) ? u2x[0] : u1x[0];
        end else begin
            case (s_item.func)
                FUNC_PRESSURE:    res = (pos <= u1x[0]) ? pos : u1x[0];
                FUNC_TEMPERATURE: res = pos;
                FUNC_SPECIES:     res = (lim > 0) ? lim : '0;
                default:          res = u1x[0];
            endcase
        end
    end

    // build the queue entry
    always_comb begin
        is_vel            = (s_item.func == FUNC_VELOCITY);
        push_entry.is_vel = is_vel;
        push_entry.npo    = npo_reg;
        push_entry.u1[0]  = s_item.first_a;
        push_entry.u1[1]  = s_item.first_b;
        push_entry.u1[2]  = s_item.first_c;
        push_entry.s[0]   = s_item.face_x;
        push_entry.s[1]   = s_item.face_y;
        push_entry.s[2]   = s_item.face_z;
        if (is_vel) begin
            push_entry.alt[0] = sat_val(ext[0]);
            push_entry.alt[1] = sat_val(ext[1]);
            push_entry.alt[2] = sat_val(ext[2]);
        end else begin
            push_entry.alt[0] = sat_val(res);
            push_entry.alt[1] = '0;
            push_entry.alt[2] = '0;
        end
    end

endmodule

>>> rtl/core/ohf_queue.sv
// Two-entry item queue between front and back.
module ohf_queue import ohf_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   head_valid,
    output entry_t head
);

    entry_t     ent_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = ent_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_reg <= !wr_reg;
            end
            if (pop) begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    // hold item storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/ohf_back.sv
// Back end: dot products, reflection divide, result select and output register.
module ohf_back import ohf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      head_valid,
    input  entry_t    head,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic en;

    logic signed [PROD_WIDTH-1:0]  ss_p [3];
    logic signed [PROD_WIDTH-1:0]  us_p [3];
    logic signed [PROD2_WIDTH-1:0] ds_p [3];
    logic signed [PROD2_WIDTH-1:0] un_p [3];
    val_t                          q    [3];

    entry_t                      e1_reg [MUL_LAT];
    logic [MUL_LAT-1:0]          v1_reg;
    logic signed [SUM_WIDTH-1:0] nn_reg;
    logic signed [SUM_WIDTH-1:0] dd_reg;
    entry_t                      es1_reg;
    logic                        vs1_reg;
    logic signed [DBL_WIDTH-1:0] d2;
    logic signed [DBL_WIDTH-1:0] nnx;
    side_t                       sd1;

    side_t                       e2_reg  [MUL_LAT];
    logic [SUM_WIDTH-1:0]        nn2_reg [MUL_LAT];
    logic [MUL_LAT-1:0]          v2_reg;
    logic signed [NUM_WIDTH-1:0] num_reg [3];
    logic [SUM_WIDTH-1:0]        den_reg;
    side_t                       es2_reg;
    logic                        vs2_reg;

    side_t                       e3_reg [DIV_LAT];
    logic [DIV_LAT-1:0]          v3_reg;
    side_t                       fin;
    out_item_t                   sel;
    out_item_t                   m_item_reg;
    logic                        m_valid_reg;

    // the whole pipe moves unless a result waits at the output
    assign en  = !m_valid_reg || m_ready;
    assign pop = en && head_valid;

    // dot products |s|^2 and u.s
    for (genvar i = 0; i < 3; i++) begin : g_p1
        ohf_mul #(.A_WIDTH(VALUE_WIDTH), .B_WIDTH(VALUE_WIDTH)) u_ss (
            .aclk(aclk), .en(en), .a(head.s[i]), .b(head.s[i]), .p(ss_p[i])
        );
        ohf_mul #(.A_WIDTH(VALUE_WIDTH), .B_WIDTH(VALUE_WIDTH)) u_us (
            .aclk(aclk), .en(en), .a(head.u1[i]), .b(head.s[i]), .p(us_p[i])
        );
    end

    // decisions on the sums
    always_comb begin
        d2          = DBL_WIDTH'(dd_reg) <<< 1;
        nnx         = DBL_WIDTH'(nn_reg);
        sd1.ent     = es1_reg;
        sd1.nn_zero = (nn_reg == '0);
        sd1.leave   = es1_reg.npo ? (dd_reg > 0) : dd_reg[SUM_WIDTH-1];
    end

    // products of the reflection numerator
    for (genvar i = 0; i < 3; i++) begin : g_p2
        ohf_mul #(.A_WIDTH(DBL_WIDTH), .B_WIDTH(VALUE_WIDTH)) u_ds (
            .aclk(aclk), .en(en), .a(d2), .b(es1_reg.s[i]), .p(ds_p[i])
        );
        ohf_mul #(.A_WIDTH(DBL_WIDTH), .B_WIDTH(VALUE_WIDTH)) u_un (
            .aclk(aclk), .en(en), .a(nnx), .b(es1_reg.u1[i]), .p(un_p[i])
        );
        ohf_div u_div (
            .aclk(aclk), .en(en), .num(num_reg[i]), .den(den_reg), .q(q[i])
        );
    end

    // valid bits along the pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= '0;
            vs1_reg     <= 1'b0;
            v2_reg      <= '0;
            vs2_reg     <= 1'b0;
            v3_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= {v1_reg[MUL_LAT-2:0], head_valid};
            vs1_reg     <= v1_reg[MUL_LAT-1];
            v2_reg      <= {v2_reg[MUL_LAT-2:0], vs1_reg};
            vs2_reg     <= v2_reg[MUL_LAT-1];
            v3_reg      <= {v3_reg[DIV_LAT-2:0], vs2_reg};
            m_valid_reg <= v3_reg[DIV_LAT-1];
        end
    end

    // carry item data alongside the arithmetic
    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg[0] <= head;
            for (int k = 1; k < MUL_LAT; k++) begin
                e1_reg[k] <= e1_reg[k-1];
            end
            nn_reg  <= SUM_WIDTH'(ss_p[0]) + SUM_WIDTH'(ss_p[1]) + SUM_WIDTH'(ss_p[2]);
            dd_reg  <= SUM_WIDTH'(us_p[0]) + SUM_WIDTH'(us_p[1]) + SUM_WIDTH'(us_p[2]);
            es1_reg <= e1_reg[MUL_LAT-1];

            e2_reg[0]  <= sd1;
            nn2_reg[0] <= nn_reg;
            for (int k = 1; k < MUL_LAT; k++) begin
                e2_reg[k]  <= e2_reg[k-1];
                nn2_reg[k] <= nn2_reg[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= NUM_WIDTH'(un_p[i]) - NUM_WIDTH'(ds_p[i]);
            end
            den_reg <= nn2_reg[MUL_LAT-1];
            es2_reg <= e2_reg[MUL_LAT-1];

            e3_reg[0] <= es2_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                e3_reg[k] <= e3_reg[k-1];
            end
            m_item_reg <= sel;
        end
    end

    // pick copy, extrapolation, reflection or scalar result
    always_comb begin
        fin              = e3_reg[DIV_LAT-1];
        sel.halo_a       = fin.ent.alt[0];
        sel.halo_b       = fin.ent.alt[1];
        sel.halo_c       = fin.ent.alt[2];
        sel.reverse_flow = 1'b0;
        if (fin.ent.is_vel) begin
            if (fin.nn_zero) begin
                sel.halo_a = fin.ent.u1[0];
                sel.halo_b = fin.ent.u1[1];
                sel.halo_c = fin.ent.u1[2];
            end else if (!fin.leave) begin
                sel.halo_a       = q[0];
                sel.halo_b       = q[1];
                sel.halo_c       = q[2];
                sel.reverse_flow = 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> rtl/core/outflow_boundary_halo_fill.sv
// Top level of the outflow boundary halo fill block.
//
//   channel | ports                               | role
//   --------+-------------------------------------+----------------------------------
//   s_      | s_valid, s_ready, s_item            | one face cell item in
//   m_      | m_valid, m_ready, m_item            | one halo result item out
//   cfg_    | cfg_valid, cfg_ready, cfg_index/data| register writes (exit mode, normal)
//
// One item per cycle sustained while m_ready is high. Path: queue slot, a chunked
// multiplier pipeline, the sum register, a second chunked multiplier pipeline, the
// numerator register, the bit-per-stage divider and the output register. Every item
// takes the same path, so order holds. Reset is synchronous and clears valid bits,
// queue pointers and the two registers. A result held at the output freezes the back
// pipe; the two-entry queue keeps s_ready high until it fills.
module outflow_boundary_halo_fill import ohf_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    logic   q_full;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   head_valid;
    entry_t head;

    ohf_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_full(q_full), .push(push), .push_entry(push_entry)
    );

    ohf_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_entry(push_entry), .pop(pop),
        .full(q_full), .head_valid(head_valid), .head(head)
    );

    ohf_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .head_valid(head_valid), .head(head), .pop(pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

endmodule

>>> rtl/core/ohf_checker.sv
// Port-level checks of the halo fill block and their binding.
module ohf_props import ohf_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input in_item_t                  s_item,
    input logic                      m_valid,
    input logic                      m_ready,
    input out_item_t                 m_item,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);

    // reset empties the output stage
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // reset empties the queue, so input is open
    a_reset_in: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // configuration is always taken
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn) cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // a waiting input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("waiting input item changed");

endmodule

bind outflow_boundary_halo_fill ohf_props u_ohf_props (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
    .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
